// File: rtl/core/cdgm_pkg.sv
// ----------------------------------------------------------------------------
// Gradient magnitude package
// Widths, register indexes and reset values shared by the gradient blocks.
// ----------------------------------------------------------------------------
package cdgm_pkg;

   localparam int PIXEL_W      = 8;
   localparam int MAG_W        = 10;  // magnitude in quarter units, 0..721
   localparam int SQ_W         = 16;  // square of an eight-bit difference
   localparam int RAD_W        = 20;  // 4 * (dx^2 + dy^2), padded to an even width
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

endpackage

// File: rtl/core/cdgm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cdgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/cdgm_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit root, two result bits per cycle; done pulses when root is final.
// ----------------------------------------------------------------------------
module cdgm_isqrt
   import cdgm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAD_W-1:0] radicand,
   output logic             done,
   output logic [MAG_W-1:0] root
);

   localparam int STEPS  = MAG_W / 2;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam int REM_W  = MAG_W + 3;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [MAG_W:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]  root_ff, root_in;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;

   always_comb begin
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      logic [MAG_W-1:0] root_t;
      logic [RAD_W-1:0] rad_t;
      rem_t  = REM_W'(rem_ff);
      root_t = root_ff;
      rad_t  = rad_ff;
      trial  = '0;
      for (int k = 0; k < 2; k++) begin
         // bring down the next two radicand bits, then try a one in the root
         rem_t = {rem_t[REM_W-3:0], rad_t[RAD_W-1 -: 2]};
         rad_t = {rad_t[RAD_W-3:0], 2'b00};
         trial = {1'b0, root_t, 2'b01};
         if (rem_t >= trial) begin
            rem_t  = rem_t - trial;
            root_t = {root_t[MAG_W-2:0], 1'b1};
         end else begin
            root_t = {root_t[MAG_W-2:0], 1'b0};
         end
      end
      rem_in  = rem_t[MAG_W:0];
      root_in = root_t;
      rad_in  = rad_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= STEP_W'(STEPS);
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            rad_ff  <= rad_in;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/core/central_difference_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// Central-difference gradient magnitude
// Raster gray pixels in, floor(2 * sqrt(dx^2 + dy^2)) per pixel out, one row late.
//
//   channel  dir  handshake          payload
//   req_     in   req_valid/stall    req_gray_pixel
//   rsp_     out  rsp_valid/stall    rsp_magnitude_quarters, rsp_last_of_run,
//                                    rsp_frame_end
//   csr_     in   csr_write          csr_index, csr_wdata
//
// One pixel at a time: each pixel passes accept, line store read at the column
// and read of the next column, then each magnitude goes through the two-bit-per-
// cycle square root; the frame-end result on the last pixel skips the root.
// Reset sets 640 x 480, restarts the frame and empties the output register.
// rsp_stall holds the output register and a result behind it; the next pixel is
// taken while a result waits there. Line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module central_difference_gradient_magnitude
   import cdgm_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_gray_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [MAG_W-1:0]       rsp_magnitude_quarters,
   output logic                   rsp_last_of_run,
   output logic                   rsp_frame_end,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WCMP_W = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;
   localparam int HCMP_W = (ROW_W + 1 > HEIGHT_REG_W) ? ROW_W + 1 : HEIGHT_REG_W;

   // result kinds caused by one pixel, in delivery order
   localparam int JOB_ROW  = 0;  // pixel one row up
   localparam int JOB_TAIL = 1;  // final row, pixel one column back
   localparam int JOB_END  = 2;  // final pixel of the frame

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_FETCH,
      S_NEXT,
      S_WAIT,
      S_OUT
   } state_type;

   state_type state_ff;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        last_col;
   logic [ROW_W-1:0]        last_row;
   logic [WCMP_W-1:0]       width_ext;
   logic [HCMP_W-1:0]       height_ext;

   logic [PIXEL_W-1:0] pix_ff;
   logic [COL_W-1:0]   cur_col_ff;
   logic [2:0]         pend_ff;
   logic [2:0]         cur_ff;
   logic [2:0]         pend_left;
   logic               dx1_ok_ff, dy1_ok_ff, dx2_ok_ff;
   logic [PIXEL_W-1:0] older_c_ff, newer_c_ff, a_prev_ff;
   logic [PIXEL_W-1:0] rec0_ff, rec1_ff;
   logic [SQ_W-1:0]    sqx1_ff, sqy1_ff, sqx2_ff;
   logic [SQ_W:0]      sum1;
   logic [MAG_W-1:0]   mag_ff;

   logic               rsp_valid_ff;
   logic [MAG_W-1:0]   rsp_mag_ff;
   logic               rsp_last_ff;
   logic               rsp_fend_ff;

   logic               mem_we;
   logic [COL_W-1:0]   rd_addr;
   logic [PIXEL_W-1:0] older_q, newer_q;

   logic               sqrt_start;
   logic [RAD_W-1:0]   sqrt_rad;
   logic               sqrt_done;
   logic [MAG_W-1:0]   sqrt_root;

   logic               accept;
   logic               out_free;
   logic               out_load;

   function automatic logic [SQ_W-1:0] diff_sq(input logic [PIXEL_W-1:0] a,
                                                input logic [PIXEL_W-1:0] b,
                                                input logic               ok);
      logic [PIXEL_W-1:0] ad;
      ad = (a >= b) ? a - b : b - a;
      return ok ? SQ_W'(ad) * SQ_W'(ad) : '0;
   endfunction

   // effective frame size: zero counts as one, oversize clamps to the maximum
   assign width_ext  = WCMP_W'(width_ff);
   assign height_ext = HCMP_W'(height_ff);

   always_comb begin
      if (width_ff == '0) begin
         last_col = '0;
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(width_ext - WCMP_W'(1));
      end
      if (height_ff == '0) begin
         last_row = '0;
      end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
         last_row = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         last_row = ROW_W'(height_ext - HCMP_W'(1));
      end
   end

   always_comb begin
      if (col_ff == last_col) begin
         col_in = '0;
         row_in = (row_ff == last_row) ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
         row_in = row_ff;
      end
   end

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == S_OUT) && out_free;

   // line stores: read the current column while idle, the next one after accept
   assign mem_we  = (state_ff == S_READ);
   assign rd_addr = (state_ff == S_IDLE) ? col_ff : cur_col_ff + 1'b1;

   cdgm_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_older_row (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (cur_col_ff),
      .wr_data (newer_q),
      .rd_addr (rd_addr),
      .rd_data (older_q)
   );

   cdgm_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_newer_row (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (cur_col_ff),
      .wr_data (pix_ff),
      .rd_addr (rd_addr),
      .rd_data (newer_q)
   );

   assign sum1       = {1'b0, sqx1_ff} + {1'b0, sqy1_ff};
   assign sqrt_rad   = pend_ff[JOB_ROW] ? RAD_W'({sum1, 2'b00}) : RAD_W'({sqx2_ff, 2'b00});
   assign sqrt_start = (state_ff == S_NEXT) && (pend_ff[JOB_ROW] || pend_ff[JOB_TAIL]);

   cdgm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign pend_left = pend_ff & ~cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= '0;
         cur_ff       <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pix_ff     <= req_gray_pixel;
                  cur_col_ff <= col_ff;
                  pend_ff[JOB_ROW]  <= (row_ff != '0);
                  pend_ff[JOB_TAIL] <= (row_ff == last_row) && (col_ff != '0);
                  pend_ff[JOB_END]  <= (row_ff == last_row) && (col_ff == last_col);
                  dy1_ok_ff  <= (row_ff > ROW_W'(1));
                  dx1_ok_ff  <= (col_ff != '0) && (col_ff != last_col);
                  dx2_ok_ff  <= (col_ff > COL_W'(1));
                  col_ff     <= col_in;
                  row_ff     <= row_in;
                  state_ff   <= S_READ;
               end
            end
            S_READ: begin
               older_c_ff <= older_q;
               newer_c_ff <= newer_q;
               state_ff   <= S_FETCH;
            end
            S_FETCH: begin
               // newer_q now holds the row above at the next column
               sqx1_ff   <= diff_sq(newer_q, a_prev_ff, dx1_ok_ff);
               sqy1_ff   <= diff_sq(older_c_ff, pix_ff, dy1_ok_ff);
               sqx2_ff   <= diff_sq(pix_ff, rec1_ff, dx2_ok_ff);
               a_prev_ff <= newer_c_ff;
               rec1_ff   <= rec0_ff;
               rec0_ff   <= pix_ff;
               state_ff  <= (pend_ff != '0) ? S_NEXT : S_IDLE;
            end
            S_NEXT: begin
               priority if (pend_ff[JOB_ROW]) begin
                  cur_ff   <= 3'b001 << JOB_ROW;
                  state_ff <= S_WAIT;
               end else if (pend_ff[JOB_TAIL]) begin
                  cur_ff   <= 3'b001 << JOB_TAIL;
                  state_ff <= S_WAIT;
               end else begin
                  cur_ff   <= 3'b001 << JOB_END;
                  mag_ff   <= '0;
                  state_ff <= S_OUT;
               end
            end
            S_WAIT: begin
               if (sqrt_done) begin
                  mag_ff   <= sqrt_root;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // hold until the output register is free
               if (out_free) begin
                  pend_ff      <= pend_left;
                  state_ff     <= (pend_left == '0) ? S_IDLE : S_NEXT;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // a size write restarts the frame
         if (csr_write) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end
      end
   end

   // output register: load a finished result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
         rsp_mag_ff   <= mag_ff;
         rsp_last_ff  <= (pend_left == '0);
         rsp_fend_ff  <= cur_ff[JOB_END];
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall              = (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_magnitude_quarters = rsp_mag_ff;
   assign rsp_last_of_run        = rsp_last_ff;
   assign rsp_frame_end          = rsp_fend_ff;

endmodule

// File: dv/central_difference_gradient_magnitude_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient magnitude testbench
// Streams raster gray pixels through the block under a range of frame sizes
// and handshake pacing, predicts every magnitude result in the bench and
// compares results field by field, in order.
// ----------------------------------------------------------------------------
module central_difference_gradient_magnitude_tb;
   import cdgm_pkg::*;

   localparam int MAX_W          = 2048;
   localparam int MAX_H          = 4096;
   localparam int LONG_HOLD      = 300;
   localparam int TAIL_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic             last_of_run;
      logic             frame_end;
   } grad_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_gray_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [MAG_W-1:0]       rsp_magnitude_quarters;
   logic                   rsp_last_of_run;
   logic                   rsp_frame_end;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   central_difference_gradient_magnitude #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_gray_pixel         (req_gray_pixel),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_magnitude_quarters (rsp_magnitude_quarters),
      .rsp_last_of_run        (rsp_last_of_run),
      .rsp_frame_end          (rsp_frame_end),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [WIDTH_REG_W-1:0]  frame_width  = WIDTH_RESET;
   logic [HEIGHT_REG_W-1:0] frame_height = HEIGHT_RESET;
   logic [PIXEL_W-1:0]      older_row [MAX_W];
   logic [PIXEL_W-1:0]      newer_row [MAX_W];
   logic [PIXEL_W-1:0]      prev_pixel [2] = '{'0, '0};
   int unsigned             col_pos = 0;
   int unsigned             row_pos = 0;

   logic [PIXEL_W-1:0] pending_pixels [$];
   grad_result_type    expected_grads [$];

   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_asks = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned error_count = 0;
   int unsigned pixels_taken = 0;
   int unsigned grads_checked = 0;
   int unsigned quiet_cycles = 0;
   int unsigned size_settings = 0;

   function automatic int unsigned usable_size(input int unsigned v, input int unsigned top);
      return (v == 0) ? 1 : ((v > top) ? top : v);
   endfunction

   // floor(sqrt(4 * (dx^2 + dy^2))), one result bit at a time from the top
   function automatic logic [MAG_W-1:0] quarter_mag(input int dx, input int dy);
      int unsigned rad, root, trial;
      rad = 4 * unsigned'(dx * dx + dy * dy);
      root = 0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = root | (1 << b);
         if (trial * trial <= rad) root = trial;
      end
      return root[MAG_W-1:0];
   endfunction

   function automatic void load_size_reg(input logic [CSR_INDEX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_IMAGE_WIDTH:  frame_width  = value[WIDTH_REG_W-1:0];
         CSR_IMAGE_HEIGHT: frame_height = value[HEIGHT_REG_W-1:0];
         default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
   endfunction

   function automatic void predict_pixel(input logic [PIXEL_W-1:0] px);
      int unsigned     w, h, col, row;
      int              dx, dy, n;
      grad_result_type found [3];
      w = usable_size(frame_width, MAX_W);
      h = usable_size(frame_height, MAX_H);
      col = (col_pos >= w) ? w - 1 : col_pos;
      row = (row_pos >= h) ? h - 1 : row_pos;
      n = 0;
      // result for the pixel one row up
      if (row >= 1) begin
         dy = (row >= 2) ? int'(older_row[col]) - int'(px) : 0;
         dx = (col >= 1 && col + 1 < w) ?
              int'(newer_row[col + 1]) - int'(older_row[col - 1]) : 0;
         found[n] = '{quarter_mag(dx, dy), 1'b0, 1'b0};
         n++;
      end
      // bottom row: one column behind, then flush the corner
      if (row == h - 1) begin
         if (col >= 1) begin
            dx = (col >= 2) ? int'(px) - int'(prev_pixel[1]) : 0;
            found[n] = '{quarter_mag(dx, 0), 1'b0, 1'b0};
            n++;
         end
         if (col == w - 1) begin
            found[n] = '{'0, 1'b0, 1'b1};
            n++;
         end
      end
      if (n > 0) found[n - 1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_grads.push_back(found[i]);

      older_row[col] = newer_row[col];
      newer_row[col] = px;
      prev_pixel[1] = prev_pixel[0];
      prev_pixel[0] = px;
      if (col + 1 >= w) begin
         col_pos = 0;
         row_pos = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
         row_pos = row;
      end
   endfunction

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom_range(255));
      endcase
   endfunction

   // pixel driver: hold each transaction until taken, then advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_pixel(req_gray_pixel);
            pixels_taken <= pixels_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_gray_pixel <= pending_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and output stall
   always @(posedge clock) begin : result_monitor
      grad_result_type want;
      int              errs;
      errs = 0;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_grads.size() == 0) begin
            $error("unexpected result: magnitude_quarters %0d last_of_run %0b frame_end %0b",
                   rsp_magnitude_quarters, rsp_last_of_run, rsp_frame_end);
            errs++;
         end else begin
            want = expected_grads.pop_front();
            if (rsp_magnitude_quarters !== want.magnitude) begin
               $error("magnitude_quarters: expected %0d, actual %0d",
                      want.magnitude, rsp_magnitude_quarters);
               errs++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, actual %0b",
                      want.last_of_run, rsp_last_of_run);
               errs++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, actual %0b", want.frame_end, rsp_frame_end);
               errs++;
            end
         end
         grads_checked <= grads_checked + 1;
      end
      error_count <= error_count + errs;

      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // end the run if no transaction moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("central_difference_gradient_magnitude_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // sample between edges so the driver's queue and valid have both settled
   task automatic wait_results();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_grads.size() != 0)
         @(negedge clock);
   endtask

   // drain, then give the block time to finish pixels that produce nothing
   task automatic settle();
      wait_results();
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      load_size_reg(idx, value);
   endtask

   task automatic start_size(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                             input int unsigned gap, input int unsigned stall);
      settle();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      send_gap_pct <= gap;
      recv_stall_pct <= stall;
      size_settings++;
   endtask

   task automatic feed_random(input int unsigned count);
      repeat (count) pending_pixels.push_back(rand_pixel());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset size 640 x 480: the start of row zero gives nothing
      feed_random(16);

      // center pixel with full-scale differences both ways
      start_size(13'd3, 13'd3, 0, 0);
      pending_pixels = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0};
      // zero sizes clamp to a single pixel frame
      start_size(13'd0, 13'd0, 0, 0);
      pending_pixels = '{8'd255, 8'd0, 8'd170};
      // single row; width write with its unused top bit set
      start_size(13'h1003, 13'd1, 0, 0);
      pending_pixels = '{8'd0, 8'd77, 8'd255};
      // single column
      start_size(13'd1, 13'd3, 0, 0);
      pending_pixels = '{8'd255, 8'd0, 8'd0};
      start_size(13'd2, 13'd2, 0, 0);
      pending_pixels = '{8'd255, 8'd0, 8'd0, 8'd255};

      start_size(13'd4, 13'd4, 0, 0);
      feed_random(48);
      start_size(13'd5, 13'd3, 74, 0);
      feed_random(45);
      start_size(13'd7, 13'd5, 0, 74);
      feed_random(35);
      // sender pauses mid-frame until every result is back
      start_size(13'd6, 13'd6, 13, 13);
      feed_random(33);
      wait_results();
      feed_random(39);
      start_size(13'd1, 13'd6, 0, 0);
      feed_random(24);
      start_size(13'd9, 13'd1, 0, 74);
      feed_random(27);
      start_size(13'd3, 13'd8191, 13, 13);
      feed_random(45);
      // long output hold while pixels keep coming: block backs up into req_stall
      start_size(13'd16, 13'd2, 0, 0);
      feed_random(64);
      hold_asks <= hold_asks + 1;
      start_size(13'd2, 13'd2, 74, 0);
      feed_random(40);
      start_size(13'd8, 13'd3, 0, 74);
      feed_random(24);

      // width above the maximum clamps to the widest row
      start_size(13'd4095, 13'd1, 0, 0);
      feed_random(20);

      settle();
      $display("%0d pixels driven, %0d results checked over %0d frame sizes",
               pixels_taken, grads_checked, size_settings);
      $display("pacing: free run, sender gaps, output stalls, both, long hold, mid-frame pause");
      if (error_count == 0) begin
         $display("central_difference_gradient_magnitude_tb: done, clean");
      end else begin
         $display("central_difference_gradient_magnitude_tb: done, errors");
      end
      $finish;
   end

endmodule
